// File: hw/rtl/rbmc_pkg.sv
`default_nettype none

package rbmc_pkg;

    localparam int MAX_TILE_LOG2 = 8;
    localparam int CFG_W = 4;
    localparam int LEVEL_W = 4;
    localparam int COORD_W = 7;
    localparam int CHAN_W = 8;
    localparam logic [CFG_W-1:0] TILE_LOG2_RESET = 4'd8;
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        pixel_t             pix;
    } slot_t;

    typedef struct packed {
        logic valid;
        logic active;
    } ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/rbmc_cell.sv
`default_nettype none

module rbmc_cell #(
    parameter int MAX_TILE_LOG2 = rbmc_pkg::MAX_TILE_LOG2,
    parameter int LEVEL = 0
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         advance,
    input  wire                                         clear,
    input  wire  [$clog2(MAX_TILE_LOG2+1)-1:0]          lv,
    input  rbmc_pkg::ctl_t                              in_ctl,
    input  rbmc_pkg::pixel_t                            in_pix,
    input  wire  [MAX_TILE_LOG2-1:0]                    in_mask,
    input  rbmc_pkg::slot_t [MAX_TILE_LOG2-1:0]         in_slots,
    output rbmc_pkg::ctl_t                              out_ctl,
    output rbmc_pkg::pixel_t                            out_pix,
    output logic [MAX_TILE_LOG2-1:0]                    out_mask,
    output rbmc_pkg::slot_t [MAX_TILE_LOG2-1:0]         out_slots
);

    localparam int LV_W = $clog2(MAX_TILE_LOG2 + 1);
    localparam int LINE_AW = (MAX_TILE_LOG2 - LEVEL - 1 > 0) ? MAX_TILE_LOG2 - LEVEL - 1 : 1;
    localparam int LINE_DEPTH = 1 << LINE_AW;

    logic [MAX_TILE_LOG2-1:0] col_reg, col_next;
    logic [MAX_TILE_LOG2-1:0] row_reg, row_next;
    logic [MAX_TILE_LOG2-1:0] col_half, row_half, col_next_half;
    logic [MAX_TILE_LOG2-1:0] size_m1;
    rbmc_pkg::pixel_t         left_reg, left_next;
    logic [26:0]              line_mem [LINE_DEPTH];
    logic [26:0]              rd_reg;
    logic                     level_on, proc, last_col, last_row, line_we;
    logic [8:0]               pr, pg, pb;
    logic [9:0]               sr, sg, sb;

    rbmc_pkg::ctl_t                      ctl_reg, ctl_next;
    rbmc_pkg::pixel_t                    pix_reg, pix_next;
    logic [MAX_TILE_LOG2-1:0]            mask_reg, mask_next;
    rbmc_pkg::slot_t [MAX_TILE_LOG2-1:0] slots_reg, slots_next;

    always_comb
    begin
        level_on = LV_W'(LEVEL) < lv;
        size_m1 = (MAX_TILE_LOG2'(1) << (lv - LV_W'(LEVEL))) - 1'b1;
        last_col = col_reg == size_m1;
        last_row = row_reg == size_m1;
        proc = advance && in_ctl.valid && in_ctl.active && level_on;
        col_half = col_reg >> 1;
        row_half = row_reg >> 1;

        pr = {1'b0, left_reg.red} + {1'b0, in_pix.red};
        pg = {1'b0, left_reg.green} + {1'b0, in_pix.green};
        pb = {1'b0, left_reg.blue} + {1'b0, in_pix.blue};
        sr = {1'b0, rd_reg[8:0]} + {1'b0, pr};
        sg = {1'b0, rd_reg[17:9]} + {1'b0, pg};
        sb = {1'b0, rd_reg[26:18]} + {1'b0, pb};

        col_next = col_reg;
        row_next = row_reg;
        left_next = left_reg;
        line_we = 1'b0;
        ctl_next = in_ctl;
        pix_next = in_pix;
        mask_next = in_mask;
        slots_next = in_slots;

        if (proc)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end

            if (!col_reg[0])
            begin
                left_next = in_pix;
                ctl_next.active = 1'b0;
            end
            else if (!row_reg[0])
            begin
                line_we = 1'b1;
                ctl_next.active = 1'b0;
            end
            else
            begin
                pix_next.red = sr[9:2];
                pix_next.green = sg[9:2];
                pix_next.blue = sb[9:2];
                mask_next[LEVEL] = 1'b1;
                slots_next[LEVEL].done = lv == LV_W'(LEVEL + 1);
                slots_next[LEVEL].col = 7'(col_half);
                slots_next[LEVEL].row = 7'(row_half);
                slots_next[LEVEL].pix = pix_next;
            end
        end

        if (clear)
        begin
            col_next = '0;
            row_next = '0;
        end

        col_next_half = col_next >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            ctl_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (advance)
            begin
                ctl_reg <= ctl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        if (advance)
        begin
            pix_reg <= pix_next;
            mask_reg <= mask_next;
            slots_reg <= slots_next;
        end
    end

    // The read address follows the counter value that the next pixel will see.
    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[col_half[LINE_AW-1:0]] <= {pb, pg, pr};
        end
        rd_reg <= line_mem[col_next_half[LINE_AW-1:0]];
    end

    assign out_ctl = ctl_reg;
    assign out_pix = pix_reg;
    assign out_mask = mask_reg;
    assign out_slots = slots_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rbmc_serializer.sv
`default_nettype none

module rbmc_serializer #(
    parameter int MAX_TILE_LOG2 = rbmc_pkg::MAX_TILE_LOG2
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         push_valid,
    input  wire  [MAX_TILE_LOG2-1:0]                    push_mask,
    input  rbmc_pkg::slot_t [MAX_TILE_LOG2-1:0]         push_slots,
    output logic                                        full,
    output logic                                        out_valid,
    input  wire                                         out_stall,
    output logic [rbmc_pkg::LEVEL_W-1:0]                level,
    output logic [rbmc_pkg::COORD_W-1:0]                col,
    output logic [rbmc_pkg::COORD_W-1:0]                row,
    output logic [rbmc_pkg::CHAN_W-1:0]                 red_out,
    output logic [rbmc_pkg::CHAN_W-1:0]                 green_out,
    output logic [rbmc_pkg::CHAN_W-1:0]                 blue_out,
    output logic                                        last_of_run,
    output logic                                        tile_done
);

    localparam int PTR_W = $clog2(rbmc_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(rbmc_pkg::FIFO_DEPTH + 1);
    localparam int SLOT_IW = (MAX_TILE_LOG2 > 1) ? $clog2(MAX_TILE_LOG2) : 1;

    logic [MAX_TILE_LOG2-1:0]            mask_mem [rbmc_pkg::FIFO_DEPTH];
    rbmc_pkg::slot_t [MAX_TILE_LOG2-1:0] slot_mem [rbmc_pkg::FIFO_DEPTH];

    logic [PTR_W-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [MAX_TILE_LOG2-1:0] remain_reg, remain_next;
    logic [MAX_TILE_LOG2-1:0] head_mask, pick_bit, rest_mask;
    logic [SLOT_IW-1:0]       pick;
    logic                     push, pop, load, emit, last;
    rbmc_pkg::slot_t          head_slot;

    logic                          out_valid_reg;
    logic [rbmc_pkg::LEVEL_W-1:0]  level_reg;
    rbmc_pkg::slot_t               slot_reg;
    logic                          last_reg;

    always_comb
    begin
        full = count_reg == CNT_W'(rbmc_pkg::FIFO_DEPTH);
        push = push_valid && (|push_mask) && !full;
        head_mask = mask_mem[rd_ptr_reg] & remain_reg;

        pick = '0;
        for (int i = MAX_TILE_LOG2 - 1; i >= 0; i--)
        begin
            if (head_mask[i])
            begin
                pick = SLOT_IW'(i);
            end
        end

        pick_bit = MAX_TILE_LOG2'(1) << pick;
        rest_mask = head_mask & ~pick_bit;
        head_slot = slot_mem[rd_ptr_reg][pick];
        load = !out_valid_reg || !out_stall;
        emit = load && (count_reg != '0);
        last = rest_mask == '0;
        pop = emit && last;

        remain_next = remain_reg;
        if (emit)
        begin
            remain_next = last ? '1 : (remain_reg & ~pick_bit);
        end

        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
            remain_reg <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            remain_reg <= remain_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (load)
            begin
                out_valid_reg <= count_reg != '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mask_mem[wr_ptr_reg] <= push_mask;
            slot_mem[wr_ptr_reg] <= push_slots;
        end
        if (emit)
        begin
            level_reg <= rbmc_pkg::LEVEL_W'(pick) + 1'b1;
            slot_reg <= head_slot;
            last_reg <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign level = level_reg;
    assign col = slot_reg.col;
    assign row = slot_reg.row;
    assign red_out = slot_reg.pix.red;
    assign green_out = slot_reg.pix.green;
    assign blue_out = slot_reg.pix.blue;
    assign last_of_run = last_reg;
    assign tile_done = slot_reg.done;

endmodule

`default_nettype wire

// File: hw/rtl/rgb_box_filter_mip_chain_unit.sv
// A pixel passes through the registered level cells in order, then the result queue and the output
// register; further results of the same pixel follow one per cycle while out_stall is low.
// Throughput: one pixel per cycle through the chain of level cells; results leave one per
// cycle while out_stall is low, and input stalls only while a pixel with results leaves the chain and finds the
// four-entry result queue full.
// Reset clears all level counters and sets tile_size_log2 to 8; line stores are not cleared.
`default_nettype none

module rgb_box_filter_mip_chain_unit #(
    parameter int MAX_TILE_LOG2 = rbmc_pkg::MAX_TILE_LOG2
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_write,
    input  wire  [rbmc_pkg::CFG_W-1:0]         cfg_data,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire  [rbmc_pkg::CHAN_W-1:0]        red,
    input  wire  [rbmc_pkg::CHAN_W-1:0]        green,
    input  wire  [rbmc_pkg::CHAN_W-1:0]        blue,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic [rbmc_pkg::LEVEL_W-1:0]       level,
    output logic [rbmc_pkg::COORD_W-1:0]       col,
    output logic [rbmc_pkg::COORD_W-1:0]       row,
    output logic [rbmc_pkg::CHAN_W-1:0]        red_out,
    output logic [rbmc_pkg::CHAN_W-1:0]        green_out,
    output logic [rbmc_pkg::CHAN_W-1:0]        blue_out,
    output logic                               last_of_run,
    output logic                               tile_done
);

    localparam int LV_W = $clog2(MAX_TILE_LOG2 + 1);

    logic [rbmc_pkg::CFG_W-1:0] tsl_reg;
    logic [LV_W-1:0]            lv;
    logic                       advance, full;

    rbmc_pkg::ctl_t                      stage_ctl   [MAX_TILE_LOG2+1];
    rbmc_pkg::pixel_t                    stage_pix   [MAX_TILE_LOG2+1];
    logic [MAX_TILE_LOG2-1:0]            stage_mask  [MAX_TILE_LOG2+1];
    rbmc_pkg::slot_t [MAX_TILE_LOG2-1:0] stage_slots [MAX_TILE_LOG2+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsl_reg <= rbmc_pkg::TILE_LOG2_RESET;
        end
        else if (cfg_write)
        begin
            tsl_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (tsl_reg == '0)
        begin
            lv = LV_W'(1);
        end
        else if (32'(tsl_reg) > MAX_TILE_LOG2)
        begin
            lv = LV_W'(MAX_TILE_LOG2);
        end
        else
        begin
            lv = LV_W'(tsl_reg);
        end

        stage_ctl[0].valid = in_valid;
        stage_ctl[0].active = 1'b1;
        stage_pix[0].red = red;
        stage_pix[0].green = green;
        stage_pix[0].blue = blue;
        stage_mask[0] = '0;
        stage_slots[0] = '0;

        advance = !(full && stage_ctl[MAX_TILE_LOG2].valid && (|stage_mask[MAX_TILE_LOG2]));
        in_stall = !advance;
    end

    for (genvar k = 0; k < MAX_TILE_LOG2; k++)
    begin : g_cell
        rbmc_cell #(
            .MAX_TILE_LOG2(MAX_TILE_LOG2),
            .LEVEL(k)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .advance(advance),
            .clear(cfg_write),
            .lv(lv),
            .in_ctl(stage_ctl[k]),
            .in_pix(stage_pix[k]),
            .in_mask(stage_mask[k]),
            .in_slots(stage_slots[k]),
            .out_ctl(stage_ctl[k+1]),
            .out_pix(stage_pix[k+1]),
            .out_mask(stage_mask[k+1]),
            .out_slots(stage_slots[k+1])
        );
    end

    rbmc_serializer #(
        .MAX_TILE_LOG2(MAX_TILE_LOG2)
    ) u_serializer (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(stage_ctl[MAX_TILE_LOG2].valid),
        .push_mask(stage_mask[MAX_TILE_LOG2]),
        .push_slots(stage_slots[MAX_TILE_LOG2]),
        .full(full),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .level(level),
        .col(col),
        .row(row),
        .red_out(red_out),
        .green_out(green_out),
        .blue_out(blue_out),
        .last_of_run(last_of_run),
        .tile_done(tile_done)
    );

    // The chain only halts for a finished pixel that has results and finds the queue full.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (stage_ctl[MAX_TILE_LOG2].valid && (|stage_mask[MAX_TILE_LOG2]) && full))
        else $error("input stalled without a blocked result vector");

    // A cascade stops at its first break, so the levels it reached start at level one.
    a_mask_contig: assert property (@(posedge clk) disable iff (!rst_n)
        stage_ctl[MAX_TILE_LOG2].valid |->
            ((stage_mask[MAX_TILE_LOG2] & (stage_mask[MAX_TILE_LOG2] + 1'b1)) == '0))
        else $error("result levels of one pixel are not contiguous");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tile_done) |-> last_of_run)
        else $error("tile end transaction is not the last of its run");

endmodule

`default_nettype wire
